FILE: rtl/fgm_pkg.sv
// Package for the font glyph scan and text measure block.
// Holds the glyph count, item kind codes, scan status codes, FSM state type
// and the command/status structs shared by the controller and the datapath.
package fgm_pkg;

    localparam int GLYPH_COUNT = 96;
    localparam int IDX_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam logic [7:0] GLYPH_COUNT_B = 8'(GLYPH_COUNT);

    localparam logic [1:0] KIND_SCAN  = 2'd0;
    localparam logic [1:0] KIND_TEXT  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam logic [1:0] SCAN_BUSY  = 2'd0;
    localparam logic [1:0] SCAN_VALID = 2'd1;
    localparam logic [1:0] SCAN_FEW   = 2'd2;
    localparam logic [1:0] SCAN_MANY  = 2'd3;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_FIRST   = 8'd32;

    localparam logic [15:0] LINE_HEIGHT_RESET = 16'd7;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } fgm_state_t;

    typedef struct packed {
        logic load;
        logic commit;
    } fgm_cmd_t;

    typedef struct packed {
        logic out_full;
    } fgm_status_t;

endpackage

FILE: rtl/fgm_if.sv
// Channel interfaces of the font glyph scan and text measure block.
// Depends on nothing; each carries valid, ready and its payload.
interface fgm_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] pixel_color;
    logic        first_pixel;
    logic        last_pixel;
    logic [7:0]  char_code;
    logic        text_start;

    modport source (output valid, kind, pixel_color, first_pixel, last_pixel,
                    char_code, text_start, input ready);
    modport sink (input valid, kind, pixel_color, first_pixel, last_pixel,
                  char_code, text_start, output ready);
endinterface

interface fgm_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  glyph_width;
    logic [15:0] glyph_offset;
    logic        code_invalid;
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic [1:0]  scan_status;

    modport source (output valid, glyph_width, glyph_offset, code_invalid,
                    box_width, box_height, scan_status, input ready);
    modport sink (input valid, glyph_width, glyph_offset, code_invalid,
                  box_width, box_height, scan_status, output ready);
endinterface

interface fgm_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

FILE: rtl/fgm_ctrl.sv
// Controller of the font glyph scan and text measure block.
// Depends on fgm_pkg; sequences load and commit of one word at a time.
module fgm_ctrl
    import fgm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        result_ready,
    input  fgm_status_t status,
    output logic        item_ready,
    output fgm_cmd_t    cmd
);

    fgm_state_t state_reg;
    fgm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        item_ready = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // The result register must be free, or be emptied this cycle.
                if (!status.out_full || result_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/fgm_datapath.sv
// Datapath of the font glyph scan and text measure block: glyph tables,
// scan counters, text box accumulators and the result register.
// Depends on fgm_pkg and the channel interfaces in fgm_if.
module fgm_datapath
    import fgm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  fgm_cmd_t            cmd,
    output fgm_status_t         status,
    fgm_item_if.sink            items,
    fgm_result_if.source        results,
    input  logic                cfg_write,
    input  logic [15:0]         cfg_data
);

    logic [7:0]  width_mem  [GLYPH_COUNT];
    logic [15:0] offset_mem [GLYPH_COUNT];

    logic [15:0] line_height_reg;

    logic [1:0]  kind_reg;
    logic [15:0] color_reg;
    logic        first_reg;
    logic        last_reg;
    logic [7:0]  code_reg;
    logic        tstart_reg;
    logic [7:0]  rd_width_reg;
    logic [15:0] rd_offset_reg;

    logic [15:0] prev_color_reg, prev_color_next;
    logic [7:0]  run_index_reg, run_index_next;
    logic [15:0] pixel_pos_reg, pixel_pos_next;
    logic        overflow_reg, overflow_next;
    logic [7:0]  cur_width_reg, cur_width_next;
    logic [1:0]  scan_result_reg, scan_result_next;
    logic [15:0] line_width_reg, line_width_next;
    logic [15:0] max_width_reg, max_width_next;
    logic [15:0] text_height_reg, text_height_next;

    logic        out_valid_reg;
    logic [7:0]  out_width_reg, out_width_next;
    logic [15:0] out_offset_reg, out_offset_next;
    logic        out_invalid_reg, out_invalid_next;

    logic [7:0]  in_code_idx;
    logic        in_lookup_ok;
    logic [IDX_W-1:0] rd_addr;

    logic [7:0]  code_idx;
    logic        lookup_ok;
    logic [7:0]  lk_width;
    logic [15:0] lk_offset;

    logic             width_we;
    logic [IDX_W-1:0] width_waddr;
    logic [7:0]       width_wdata;
    logic             offset_we;
    logic [IDX_W-1:0] offset_waddr;
    logic [15:0]      offset_wdata;

    logic [7:0]  run_plus;
    logic [16:0] line_sum;
    logic [16:0] height_sum;
    logic [15:0] lw_base;
    logic [15:0] mw_base;
    logic [15:0] th_base;

    assign status.out_full = out_valid_reg;

    // Table read address for the incoming word.
    assign in_code_idx  = items.char_code - CHAR_FIRST;
    assign in_lookup_ok = (items.char_code >= CHAR_FIRST) && (in_code_idx < GLYPH_COUNT_B);
    assign rd_addr      = in_lookup_ok ? in_code_idx[IDX_W-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg      <= items.kind;
            color_reg     <= items.pixel_color;
            first_reg     <= items.first_pixel;
            last_reg      <= items.last_pixel;
            code_reg      <= items.char_code;
            tstart_reg    <= items.text_start;
            rd_width_reg  <= width_mem[rd_addr];
            rd_offset_reg <= offset_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (width_we)
        begin
            width_mem[width_waddr] <= width_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (offset_we)
        begin
            offset_mem[offset_waddr] <= offset_wdata;
        end
    end

    // Entries past the run index are left stale by a first pixel, and a lookup past
    // the run index reads as zero, so the run index works as a fill count. The current run's
    // width lives in a register that mirrors its table entry.
    assign code_idx  = code_reg - CHAR_FIRST;
    assign lookup_ok = (code_reg >= CHAR_FIRST) && (code_idx < GLYPH_COUNT_B);

    always_comb
    begin
        lk_width  = 8'd0;
        lk_offset = 16'd0;
        if (lookup_ok)
        begin
            if (code_idx < run_index_reg)
            begin
                lk_width = rd_width_reg;
            end
            else if (code_idx == run_index_reg)
            begin
                lk_width = cur_width_reg;
            end
            if ((code_idx != 8'd0) && (code_idx <= run_index_reg))
            begin
                lk_offset = rd_offset_reg;
            end
        end
    end

    assign run_plus = run_index_reg + 8'd1;

    always_comb
    begin
        prev_color_next  = prev_color_reg;
        run_index_next   = run_index_reg;
        pixel_pos_next   = pixel_pos_reg;
        overflow_next    = overflow_reg;
        cur_width_next   = cur_width_reg;
        scan_result_next = scan_result_reg;
        line_width_next  = line_width_reg;
        max_width_next   = max_width_reg;
        text_height_next = text_height_reg;
        out_width_next   = 8'd0;
        out_offset_next  = 16'd0;
        out_invalid_next = 1'b0;
        width_we         = 1'b0;
        width_waddr      = run_index_reg[IDX_W-1:0];
        width_wdata      = 8'd0;
        offset_we        = 1'b0;
        offset_waddr     = run_plus[IDX_W-1:0];
        offset_wdata     = 16'd0;
        lw_base          = tstart_reg ? 16'd0 : line_width_reg;
        mw_base          = tstart_reg ? 16'd0 : max_width_reg;
        th_base          = tstart_reg ? line_height_reg : text_height_reg;
        line_sum         = {1'b0, lw_base} + {9'd0, lk_width};
        height_sum       = {1'b0, th_base} + {1'b0, line_height_reg};

        case (kind_reg)
            KIND_SCAN:
            begin
                if (first_reg)
                begin
                    prev_color_next  = color_reg;
                    run_index_next   = 8'd0;
                    pixel_pos_next   = 16'd0;
                    overflow_next    = 1'b0;
                    cur_width_next   = 8'd0;
                    scan_result_next = SCAN_BUSY;
                end
                else
                begin
                    pixel_pos_next = (pixel_pos_reg == 16'hFFFF) ? 16'hFFFF
                                                                 : pixel_pos_reg + 16'd1;
                    if (run_index_reg < GLYPH_COUNT_B)
                    begin
                        width_wdata    = (cur_width_reg == 8'hFF) ? 8'hFF
                                                                  : cur_width_reg + 8'd1;
                        width_we       = cmd.commit;
                        cur_width_next = width_wdata;
                    end
                    if (color_reg != prev_color_reg)
                    begin
                        prev_color_next = color_reg;
                        if (run_index_reg < GLYPH_COUNT_B)
                        begin
                            run_index_next = run_plus;
                            cur_width_next = 8'd0;
                            if (run_plus < GLYPH_COUNT_B)
                            begin
                                offset_we    = cmd.commit;
                                offset_wdata = pixel_pos_next;
                            end
                        end
                        else
                        begin
                            overflow_next = 1'b1;
                        end
                    end
                end
                if (last_reg)
                begin
                    if (overflow_next)
                    begin
                        scan_result_next = SCAN_MANY;
                    end
                    else if (run_index_next == GLYPH_COUNT_B)
                    begin
                        scan_result_next = SCAN_VALID;
                    end
                    else
                    begin
                        scan_result_next = SCAN_FEW;
                    end
                end
            end
            KIND_TEXT:
            begin
                text_height_next = th_base;
                if (code_reg == CHAR_NEWLINE)
                begin
                    text_height_next = height_sum[16] ? 16'hFFFF : height_sum[15:0];
                    line_width_next  = 16'd0;
                end
                else
                begin
                    out_width_next   = lk_width;
                    out_offset_next  = lk_offset;
                    out_invalid_next = !lookup_ok;
                    line_width_next  = line_sum[16] ? 16'hFFFF : line_sum[15:0];
                end
                max_width_next = (line_width_next > mw_base) ? line_width_next : mw_base;
            end
            KIND_QUERY:
            begin
                out_width_next   = lk_width;
                out_offset_next  = lk_offset;
                out_invalid_next = !lookup_ok;
            end
            default:
            begin
                out_width_next = 8'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_height_reg  <= LINE_HEIGHT_RESET;
            prev_color_reg   <= 16'd0;
            run_index_reg    <= 8'd0;
            pixel_pos_reg    <= 16'd0;
            overflow_reg     <= 1'b0;
            cur_width_reg    <= 8'd0;
            scan_result_reg  <= SCAN_BUSY;
            line_width_reg   <= 16'd0;
            max_width_reg    <= 16'd0;
            text_height_reg  <= 16'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                line_height_reg <= cfg_data;
            end
            if (cmd.commit)
            begin
                prev_color_reg  <= prev_color_next;
                run_index_reg   <= run_index_next;
                pixel_pos_reg   <= pixel_pos_next;
                overflow_reg    <= overflow_next;
                cur_width_reg   <= cur_width_next;
                scan_result_reg <= scan_result_next;
                line_width_reg  <= line_width_next;
                max_width_reg   <= max_width_next;
                text_height_reg <= text_height_next;
                out_valid_reg   <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_width_reg   <= out_width_next;
            out_offset_reg  <= out_offset_next;
            out_invalid_reg <= out_invalid_next;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.glyph_width  = out_width_reg;
    assign results.glyph_offset = out_offset_reg;
    assign results.code_invalid = out_invalid_reg;
    assign results.box_width    = max_width_reg;
    assign results.box_height   = text_height_reg;
    assign results.scan_status  = scan_result_reg;

    a_run_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_index_reg <= GLYPH_COUNT_B)
        else $error("run index passed the glyph count");

    a_overflow_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> (run_index_reg == GLYPH_COUNT_B))
        else $error("overflow flagged before the end-marker run");

    a_marker_run_no_width: assert property (@(posedge clk) disable iff (!rst_n)
        (run_index_reg == GLYPH_COUNT_B) |-> (cur_width_reg == 8'd0))
        else $error("end-marker run accumulated a width");

    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.commit))
        else $error("result word appeared without a commit");

endmodule

FILE: rtl/font_glyph_scan_and_text_measure.sv
// Each word is first captured while the glyph tables are read into registers, then the
// scan and text state are updated and the result register is loaded. A new word is
// taken while the previous result still waits in its register; a stalled result holds
// the update step until the result register is free or being emptied.
// Depends on fgm_pkg, fgm_if, fgm_ctrl and fgm_datapath.
module font_glyph_scan_and_text_measure
    import fgm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    fgm_item_if.sink     items,
    fgm_result_if.source results,
    fgm_cfg_if.sink      cfg
);

    fgm_cmd_t    cmd;
    fgm_status_t status;
    logic        item_ready;

    assign items.ready = item_ready;
    assign cfg.ready   = 1'b1;

    fgm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (items.valid),
        .result_ready (results.ready),
        .status       (status),
        .item_ready   (item_ready),
        .cmd          (cmd)
    );

    fgm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .items     (items),
        .results   (results),
        .cfg_write (cfg.valid),
        .cfg_data  (cfg.data)
    );

endmodule

FILE: dv/fgm_tb_pkg.sv
// Scoreboard for the font glyph scan and text measure testbench.
// Depends on fgm_pkg for the glyph count, item kinds, status codes and characters.
package fgm_tb_pkg;
    import fgm_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] pixel_color;
        logic        first_pixel;
        logic        last_pixel;
        logic [7:0]  char_code;
        logic        text_start;
    } glyph_word_t;

    typedef struct packed {
        logic [7:0]  glyph_width;
        logic [15:0] glyph_offset;
        logic        code_invalid;
        logic [15:0] box_width;
        logic [15:0] box_height;
        logic [1:0]  scan_status;
    } box_word_t;

    class glyph_box_scoreboard;
        int          mismatches;
        box_word_t   expected_boxes[$];
        logic [15:0] line_height;
        logic [7:0]  width_table[GLYPH_COUNT];
        logic [15:0] offset_table[GLYPH_COUNT];
        logic [15:0] prev_color;
        int          run_index;
        logic [15:0] pixel_pos;
        bit          overflow_seen;
        logic [15:0] line_width;
        logic [15:0] widest_line;
        logic [15:0] box_height;
        logic [1:0]  scan_status;

        function new();
            mismatches = 0;
            line_height = LINE_HEIGHT_RESET;
            foreach (width_table[i])
            begin
                width_table[i] = '0;
                offset_table[i] = '0;
            end
            prev_color = '0;
            run_index = 0;
            pixel_pos = '0;
            overflow_seen = 0;
            line_width = '0;
            widest_line = '0;
            box_height = '0;
            scan_status = SCAN_BUSY;
        endfunction

        function void set_line_height(logic [15:0] h);
            line_height = h;
        endfunction

        function int pending();
            return expected_boxes.size();
        endfunction

        function logic [15:0] add_sat(logic [15:0] a, int unsigned b);
            int unsigned s;
            s = a + b;
            return (s > 65535) ? 16'hFFFF : 16'(s);
        endfunction

        function bit glyph_lookup(logic [7:0] code, output logic [7:0] w,
                                  output logic [15:0] off);
            int idx;
            idx = int'(code) - int'(CHAR_FIRST);
            if (idx < 0 || idx >= GLYPH_COUNT)
            begin
                w = '0;
                off = '0;
                return 0;
            end
            w = width_table[idx];
            off = offset_table[idx];
            return 1;
        endfunction

        function void scan_pixel(glyph_word_t w);
            if (w.first_pixel)
            begin
                foreach (width_table[i])
                begin
                    width_table[i] = '0;
                    offset_table[i] = '0;
                end
                prev_color = w.pixel_color;
                run_index = 0;
                pixel_pos = '0;
                overflow_seen = 0;
                scan_status = SCAN_BUSY;
            end
            else
            begin
                pixel_pos = add_sat(pixel_pos, 1);
                if (run_index < GLYPH_COUNT && width_table[run_index] < 8'd255)
                    width_table[run_index] = width_table[run_index] + 8'd1;
                if (w.pixel_color != prev_color)
                begin
                    prev_color = w.pixel_color;
                    // Once the end-marker run is reached, a further color change
                    // only marks the row as having too many runs.
                    if (run_index < GLYPH_COUNT)
                    begin
                        run_index++;
                        if (run_index < GLYPH_COUNT)
                            offset_table[run_index] = pixel_pos;
                    end
                    else
                        overflow_seen = 1;
                end
            end
            if (w.last_pixel)
            begin
                if (overflow_seen)
                    scan_status = SCAN_MANY;
                else if (run_index == GLYPH_COUNT)
                    scan_status = SCAN_VALID;
                else
                    scan_status = SCAN_FEW;
            end
        endfunction

        function box_word_t next_box(glyph_word_t w);
            box_word_t   r;
            logic [7:0]  gw;
            logic [15:0] go;
            logic        bad;
            gw = '0;
            go = '0;
            bad = 0;
            case (w.kind)
                KIND_SCAN:
                    scan_pixel(w);
                KIND_TEXT:
                begin
                    if (w.text_start)
                    begin
                        line_width = '0;
                        widest_line = '0;
                        box_height = line_height;
                    end
                    if (w.char_code == CHAR_NEWLINE)
                    begin
                        box_height = add_sat(box_height, line_height);
                        line_width = '0;
                    end
                    else
                    begin
                        bad = !glyph_lookup(w.char_code, gw, go);
                        line_width = add_sat(line_width, gw);
                    end
                    if (line_width > widest_line)
                        widest_line = line_width;
                end
                KIND_QUERY:
                    bad = !glyph_lookup(w.char_code, gw, go);
                default:
                    ;
            endcase
            r.glyph_width = gw;
            r.glyph_offset = go;
            r.code_invalid = bad;
            r.box_width = widest_line;
            r.box_height = box_height;
            r.scan_status = scan_status;
            return r;
        endfunction

        function void note_word(glyph_word_t w);
            expected_boxes.push_back(next_box(w));
        endfunction

        function void compare_field(string name, int unsigned exp, int unsigned act);
            if (exp != act)
            begin
                $error("%s: expected %0d, got %0d", name, exp, act);
                mismatches++;
            end
        endfunction

        function void check_word(box_word_t got);
            box_word_t exp;
            if (expected_boxes.size() == 0)
            begin
                $error("result word arrived with no word outstanding");
                mismatches++;
                return;
            end
            exp = expected_boxes.pop_front();
            compare_field("glyph_width", exp.glyph_width, got.glyph_width);
            compare_field("glyph_offset", exp.glyph_offset, got.glyph_offset);
            compare_field("code_invalid", exp.code_invalid, got.code_invalid);
            compare_field("box_width", exp.box_width, got.box_width);
            compare_field("box_height", exp.box_height, got.box_height);
            compare_field("scan_status", exp.scan_status, got.scan_status);
        endfunction
    endclass

endpackage

FILE: dv/tb_top.sv
// Top-level testbench for font_glyph_scan_and_text_measure: drives scan rows,
// text and queries with random idling and checks every result word in order.
// Depends on fgm_pkg, the fgm interfaces, fgm_tb_pkg and the block itself.
module tb_top;
    import fgm_pkg::*;
    import fgm_tb_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int LONG_HOLD = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 4;

    logic clk;
    logic rst_n;
    int   gap_pct;
    int   stall_pct;
    int   hold_asks;
    int   holds_served;
    int   hold_left;
    int   quiet_cycles;

    glyph_box_scoreboard sb = new();

    fgm_item_if   items();
    fgm_result_if results();
    fgm_cfg_if    cfg();

    font_glyph_scan_and_text_measure dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .cfg     (cfg)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver: random stalls, plus a long hold counted here whenever one is asked.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            results.ready <= 1'b0;
        end
        else if (holds_served != hold_asks)
        begin
            holds_served <= holds_served + 1;
            hold_left <= LONG_HOLD;
            results.ready <= 1'b0;
        end
        else
            results.ready <= ($urandom_range(99) >= stall_pct);
        if (results.valid && results.ready)
            sb.check_word(box_word_t'({results.glyph_width, results.glyph_offset,
                                       results.code_invalid, results.box_width,
                                       results.box_height, results.scan_status}));
    end

    always @(posedge clk)
    begin
        if ((items.valid && items.ready) || (results.valid && results.ready)
            || (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_word(input glyph_word_t w);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            items.valid <= 1'b0;
            @(posedge clk);
        end
        items.valid <= 1'b1;
        items.kind <= w.kind;
        items.pixel_color <= w.pixel_color;
        items.first_pixel <= w.first_pixel;
        items.last_pixel <= w.last_pixel;
        items.char_code <= w.char_code;
        items.text_start <= w.text_start;
        @(posedge clk);
        while (!items.ready)
            @(posedge clk);
        sb.note_word(w);
    endtask

    task automatic scan_px(input logic [15:0] color, input bit first, input bit last);
        glyph_word_t w;
        w.kind = KIND_SCAN;
        w.pixel_color = color;
        w.first_pixel = first;
        w.last_pixel = last;
        w.char_code = 8'($urandom);
        w.text_start = 1'($urandom);
        send_word(w);
    endtask

    task automatic char_word(input logic [1:0] kind, input logic [7:0] code,
                             input bit start);
        glyph_word_t w;
        w.kind = kind;
        w.pixel_color = 16'($urandom);
        w.first_pixel = 1'($urandom);
        w.last_pixel = 1'($urandom);
        w.char_code = code;
        w.text_start = start;
        send_word(w);
    endtask

    task automatic random_text_or_query();
        int         pick;
        logic [7:0] code;
        pick = $urandom_range(99);
        if (pick < 12)
            code = CHAR_NEWLINE;
        else if (pick < 22)
            code = $urandom_range(1) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(128, 255));
        else
            code = 8'($urandom_range(32, 127));
        if ($urandom_range(99) < 60)
            char_word(KIND_TEXT, code, $urandom_range(99) < 12);
        else
            char_word(KIND_QUERY, code, 1'($urandom));
    endtask

    // Noise: scan, text or query words with random fields, including stray first and last marks.
    task automatic random_word();
        glyph_word_t w;
        w.kind = 2'($urandom_range(2));
        w.pixel_color = 16'($urandom);
        w.first_pixel = ($urandom_range(99) < 20);
        w.last_pixel = ($urandom_range(99) < 20);
        w.char_code = 8'($urandom);
        w.text_start = ($urandom_range(99) < 15);
        send_word(w);
    endtask

    // One marker row: runs of distinct colors, the first run first_len pixels long,
    // with text and query words mixed in between pixels.
    task automatic scan_row(input int runs, input int first_len, input bit close_row,
                            input int mix_pct);
        logic [15:0] color;
        int          len;
        color = 16'($urandom);
        for (int r = 0; r < runs; r++)
        begin
            if (r != 0)
                color = color ^ 16'($urandom_range(1, 65535));
            if (r == 0)
                len = first_len;
            else
                len = ($urandom_range(99) < 75) ? 1 : $urandom_range(2, 5);
            for (int p = 0; p < len; p++)
            begin
                if ($urandom_range(99) < mix_pct)
                    random_text_or_query();
                scan_px(color, r == 0 && p == 0,
                        close_row && r == runs - 1 && p == len - 1);
            end
        end
    endtask

    task automatic wait_drained();
        items.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_line_height(input logic [15:0] h);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.data <= h;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        sb.set_line_height(h);
    endtask

    task automatic set_idling(input int gap, input int stall);
        gap_pct = gap;
        stall_pct <= stall;
    endtask

    initial
    begin
        rst_n = 1'b0;
        items.valid = 1'b0;
        items.kind = KIND_SCAN;
        items.pixel_color = '0;
        items.first_pixel = 1'b0;
        items.last_pixel = 1'b0;
        items.char_code = '0;
        items.text_start = 1'b0;
        results.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        gap_pct = 0;
        stall_pct = 0;
        hold_asks = 0;
        holds_served = 0;
        hold_left = 0;
        quiet_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words: empty tables, text without a start, tiny rows, code edges.
        char_word(KIND_QUERY, CHAR_FIRST, 1'b0);
        char_word(KIND_TEXT, CHAR_FIRST + 8'd33, 1'b0);
        char_word(KIND_TEXT, CHAR_NEWLINE, 1'b0);
        scan_px(16'hFFFF, 1'b1, 1'b1);
        scan_px(16'h0000, 1'b1, 1'b0);
        scan_px(16'hFFFF, 1'b0, 1'b0);
        scan_px(16'hFFFF, 1'b0, 1'b1);
        char_word(KIND_QUERY, 8'd0, 1'b0);
        char_word(KIND_QUERY, CHAR_FIRST - 8'd1, 1'b0);
        char_word(KIND_QUERY, CHAR_FIRST, 1'b1);
        char_word(KIND_QUERY, CHAR_FIRST + 8'd1, 1'b0);
        char_word(KIND_QUERY, CHAR_FIRST + GLYPH_COUNT_B - 8'd1, 1'b0);
        char_word(KIND_QUERY, CHAR_FIRST + GLYPH_COUNT_B, 1'b0);
        char_word(KIND_QUERY, 8'hFF, 1'b0);
        char_word(KIND_TEXT, CHAR_FIRST + 8'd1, 1'b1);
        char_word(KIND_TEXT, CHAR_FIRST + GLYPH_COUNT_B - 8'd1, 1'b0);
        char_word(KIND_TEXT, CHAR_NEWLINE, 1'b0);
        char_word(KIND_TEXT, 8'hFF, 1'b0);
        char_word(KIND_TEXT, 8'd0, 1'b0);
        char_word(KIND_TEXT, CHAR_NEWLINE, 1'b1);
        char_word(KIND_UNUSED, 8'hFF, 1'b1);
        scan_px(16'h1234, 1'b0, 1'b1);

        // No idling; the receiver holds off while the input backs up.
        set_idling(0, 0);
        write_line_height(16'hFFFF);
        hold_asks <= hold_asks + 1;
        scan_row($urandom_range(2, 8), $urandom_range(2, 4), 1'b1, 10);
        char_word(KIND_TEXT, CHAR_NEWLINE, 1'b1);
        char_word(KIND_TEXT, CHAR_NEWLINE, 1'b0);
        repeat (20) random_text_or_query();

        // Complete row behind an idle sender.
        set_idling(72, 0);
        write_line_height(16'h0000);
        scan_row(GLYPH_COUNT + 1, $urandom_range(1, 3), 1'b1, 5);
        char_word(KIND_QUERY, CHAR_FIRST, 1'b0);
        char_word(KIND_TEXT, CHAR_FIRST, 1'b1);
        repeat (10) random_text_or_query();

        // Row with too many runs, behind a stalling receiver.
        set_idling(0, 72);
        write_line_height(16'($urandom));
        hold_asks <= hold_asks + 1;
        scan_row(GLYPH_COUNT + 3, 1, 1'b1, 5);
        repeat (10) random_text_or_query();

        // Broken sequences and noise with light idling on both sides.
        set_idling(13, 13);
        write_line_height(16'd1);
        repeat (30) random_word();
        scan_row($urandom_range(2, 10), $urandom_range(1, 3), 1'($urandom), 20);
        repeat (20) random_text_or_query();

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
